FILE: design/rgb_to_planar_tile_encoder_core_macros.svh
// assertion macros for the planar tile encoder
`ifndef RGB_TO_PLANAR_TILE_ENCODER_CORE_MACROS_SVH
`define RGB_TO_PLANAR_TILE_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RTPE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen outside reset
`define RTPE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RTPE_ASSERT(lbl, clk, rstn, prop, msg)
`define RTPE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: design/rtpe_pkg.sv
`default_nettype none

package rtpe_pkg;

  localparam int unsigned COLOR_W           = 15;
  localparam int unsigned IDX_W             = 4;
  localparam int unsigned TILE_OUT_W        = 10;
  localparam int unsigned PLANES            = 4;
  localparam int unsigned PALETTE_DEPTH_DEF = 16;
  localparam int unsigned MAX_TILES_DEF     = 1024;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QUEUE_AW          = 2;
  localparam int unsigned QUEUE_CW          = 3;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_PLANE  = 1'b1
  } kind_e;

  typedef enum logic {
    MODE_COLLECT = 1'b0,
    MODE_ENCODE  = 1'b1
  } mode_e;

  typedef enum logic {
    CFG_MODE = 1'b0,
    CFG_BG   = 1'b1
  } cfg_idx_e;

  // one queued job: a palette report or a finished row of plane bytes
  typedef struct packed {
    kind_e                      kind;
    logic [COLOR_W-1:0]         color;
    logic [IDX_W-1:0]           color_index;
    logic                       new_entry;
    logic                       palette_error;
    logic [PLANES-1:0][7:0]     planes;
    logic [2:0]                 row;
    logic [TILE_OUT_W-1:0]      tile;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // rgb888 to bgr555, red in the low bits
  function automatic logic [COLOR_W-1:0] to_bgr555(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
    return {b[7:3], g[7:3], r[7:3]};
  endfunction

endpackage

`default_nettype wire

FILE: design/rtpe_front.sv
`default_nettype none

module rtpe_front #(
  parameter int unsigned PALETTE_DEPTH = rtpe_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_TILES     = rtpe_pkg::MAX_TILES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [7:0]                      in_red_i,
  input  wire logic [7:0]                      in_green_i,
  input  wire logic [7:0]                      in_blue_i,
  output      logic                            in_stall_o,
  input  wire rtpe_pkg::mode_e                 mode_i,
  input  wire logic [rtpe_pkg::COLOR_W-1:0]    bg_color_i,
  input  wire rtpe_pkg::q_status_t             q_status_i,
  output      logic                            push_o,
  output      rtpe_pkg::rec_t                  rec_o
);

  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned PW = $clog2(PALETTE_DEPTH);
  localparam int unsigned TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  logic [rtpe_pkg::COLOR_W-1:0] pal_q [PALETTE_DEPTH];
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [7:0]                   acc_q [rtpe_pkg::PLANES];
  logic [7:0]                   acc_d [rtpe_pkg::PLANES];
  logic [2:0]                   col_q, col_d;
  logic [2:0]                   row_q, row_d;
  logic [TW-1:0]                tile_q, tile_d;
  logic                         rerr_q, rerr_d;

  logic [rtpe_pkg::COLOR_W-1:0] color;
  logic [PALETTE_DEPTH-1:0]     hit, bg_hit;
  logic                         found, bg_found_nz, pal_full;
  logic [rtpe_pkg::IDX_W-1:0]   pos, bg_pos;
  logic [rtpe_pkg::IDX_W-1:0]   enc_idx;
  logic                         enc_err, err_row;
  logic                         accept, row_end, pal_we;
  logic [2:0]                   bit_pos;
  logic [31:0]                  tile_ext;

  assign color      = rtpe_pkg::to_bgr555(in_red_i, in_green_i, in_blue_i);
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign row_end    = (col_q == 3'd7);
  assign pal_full   = (cnt_q == CW'(PALETTE_DEPTH));

  // parallel compare against the filled palette entries
  always_comb begin
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      hit[i]    = (CW'(i) < cnt_q) && (pal_q[i] == color);
      bg_hit[i] = (CW'(i) < cnt_q) && (pal_q[i] == bg_color_i) && (i != 0);
    end
  end

  // lowest matching position
  always_comb begin
    pos    = '0;
    bg_pos = '0;
    for (int i = PALETTE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pos = rtpe_pkg::IDX_W'(i);
      end
      if (bg_hit[i]) begin
        bg_pos = rtpe_pkg::IDX_W'(i);
      end
    end
  end

  assign found       = |hit;
  assign bg_found_nz = |bg_hit;

  // encode index with the background moved to entry zero
  always_comb begin
    enc_idx = '0;
    enc_err = 1'b0;
    if (color == bg_color_i) begin
      enc_idx = '0;
    end else if (found && (pos == '0)) begin
      if (bg_found_nz) begin
        enc_idx = bg_pos;
      end else begin
        enc_err = 1'b1;
      end
    end else if (found) begin
      enc_idx = pos;
    end else begin
      enc_err = 1'b1;
    end
  end

  assign err_row = rerr_q || enc_err;
  assign bit_pos = 3'd7 - col_q;

  // bitplane accumulation
  always_comb begin
    for (int p = 0; p < rtpe_pkg::PLANES; p++) begin
      acc_d[p] = acc_q[p] | ({7'b0, enc_idx[p]} << bit_pos);
    end
  end

  assign tile_ext = 32'(tile_q);

  // record toward the back end
  always_comb begin
    rec_o = '0;
    if (mode_i == rtpe_pkg::MODE_COLLECT) begin
      rec_o.kind  = rtpe_pkg::KIND_REPORT;
      rec_o.color = color;
      if (found) begin
        rec_o.color_index = pos;
      end else if (!pal_full) begin
        rec_o.color_index = rtpe_pkg::IDX_W'(cnt_q);
        rec_o.new_entry   = 1'b1;
      end else begin
        rec_o.palette_error = 1'b1;
      end
    end else begin
      rec_o.kind          = rtpe_pkg::KIND_PLANE;
      rec_o.color         = color;
      rec_o.color_index   = enc_idx;
      rec_o.palette_error = err_row;
      for (int p = 0; p < rtpe_pkg::PLANES; p++) begin
        rec_o.planes[p] = acc_d[p];
      end
      rec_o.row  = row_q;
      rec_o.tile = tile_ext[rtpe_pkg::TILE_OUT_W-1:0];
    end
  end

  assign push_o = accept && ((mode_i == rtpe_pkg::MODE_COLLECT) || row_end);
  assign pal_we = accept && (mode_i == rtpe_pkg::MODE_COLLECT) && !found && !pal_full;

  // next state for the counters
  always_comb begin
    cnt_d  = cnt_q;
    col_d  = col_q;
    row_d  = row_q;
    tile_d = tile_q;
    rerr_d = rerr_q;
    if (pal_we) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (accept && (mode_i == rtpe_pkg::MODE_ENCODE)) begin
      if (!row_end) begin
        col_d  = col_q + 3'd1;
        rerr_d = err_row;
      end else begin
        col_d  = 3'd0;
        rerr_d = 1'b0;
        row_d  = row_q + 3'd1;
        if (row_q == 3'd7) begin
          tile_d = (tile_q == TW'(MAX_TILES - 1)) ? '0 : tile_q + TW'(1);
        end
      end
    end
  end

  // palette storage, written only on a new colour
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_q[cnt_q[PW-1:0]] <= color;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      tile_q <= '0;
      rerr_q <= 1'b0;
      for (int p = 0; p < rtpe_pkg::PLANES; p++) begin
        acc_q[p] <= '0;
      end
    end else begin
      cnt_q  <= cnt_d;
      col_q  <= col_d;
      row_q  <= row_d;
      tile_q <= tile_d;
      rerr_q <= rerr_d;
      if (accept && (mode_i == rtpe_pkg::MODE_ENCODE)) begin
        for (int p = 0; p < rtpe_pkg::PLANES; p++) begin
          acc_q[p] <= row_end ? 8'h00 : acc_d[p];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rtpe_queue.sv
`default_nettype none

module rtpe_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rtpe_pkg::rec_t push_rec_i,
  input  wire logic           pop_i,
  output      rtpe_pkg::rec_t head_rec_o,
  output      rtpe_pkg::q_status_t status_o
);

  rtpe_pkg::rec_t                  buf_q [rtpe_pkg::QUEUE_DEPTH];
  logic [rtpe_pkg::QUEUE_AW-1:0]   wr_q, rd_q;
  logic [rtpe_pkg::QUEUE_CW-1:0]   cnt_q;

  assign head_rec_o     = buf_q[rd_q];
  assign status_o.full  = (cnt_q == rtpe_pkg::QUEUE_CW'(rtpe_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_rec_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + rtpe_pkg::QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + rtpe_pkg::QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + rtpe_pkg::QUEUE_CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - rtpe_pkg::QUEUE_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rtpe_back.sv
`default_nettype none

module rtpe_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rtpe_pkg::rec_t                    head_rec_i,
  input  wire rtpe_pkg::q_status_t               q_status_i,
  output      logic                              pop_o,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              out_kind_o,
  output      logic [rtpe_pkg::COLOR_W-1:0]      out_color_o,
  output      logic [rtpe_pkg::IDX_W-1:0]        out_color_index_o,
  output      logic                              out_new_entry_o,
  output      logic                              out_palette_error_o,
  output      logic [7:0]                        out_plane_byte_o,
  output      logic [4:0]                        out_byte_offset_o,
  output      logic [rtpe_pkg::TILE_OUT_W-1:0]   out_tile_number_o,
  output      logic                              out_last_o
);

  logic [1:0] beat_q;
  logic       fire, is_plane, final_beat;

  assign is_plane    = (head_rec_i.kind == rtpe_pkg::KIND_PLANE);
  assign out_valid_o = !q_status_i.empty;
  assign fire        = out_valid_o && !out_stall_i;
  assign final_beat  = !is_plane || (beat_q == 2'd3);
  assign pop_o       = fire && final_beat;

  // result fields from the head job and the beat number
  always_comb begin
    out_kind_o          = head_rec_i.kind;
    out_color_o         = head_rec_i.color;
    out_color_index_o   = head_rec_i.color_index;
    out_new_entry_o     = head_rec_i.new_entry;
    out_palette_error_o = head_rec_i.palette_error;
    out_plane_byte_o    = 8'h00;
    out_byte_offset_o   = 5'd0;
    out_tile_number_o   = '0;
    out_last_o          = 1'b0;
    if (is_plane) begin
      out_plane_byte_o  = head_rec_i.planes[beat_q];
      out_byte_offset_o = {beat_q[1], head_rec_i.row, beat_q[0]};
      out_tile_number_o = head_rec_i.tile;
      out_last_o        = (beat_q == 2'd3);
    end
  end

  // beat counter over the four plane bytes of a row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 2'd0;
    end else if (fire) begin
      beat_q <= final_beat ? 2'd0 : beat_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: design/rgb_to_planar_tile_encoder_core.sv
// RGB888 pixels in, BGR555 palette reports or 4bpp planar tile bytes out.
// mode 0 collects colours into a palette and gives one report per pixel;
// mode 1 takes pixels in tile order (eight per row, eight rows per tile) and
// gives four plane bytes after each row's eighth pixel. The front end
// compares each pixel against all palette entries at once and queues its
// report, or a finished row, in a four-entry queue; it stalls only while
// that queue is full. The back end sends one result per cycle unless the
// output stalls, so report or row runs sustain one pixel per cycle. The
// user must write configuration only while no work is pending; not enforced.
`default_nettype none

`include "rgb_to_planar_tile_encoder_core_macros.svh"

module rgb_to_planar_tile_encoder_core #(
  parameter int unsigned PALETTE_DEPTH = rtpe_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_TILES     = rtpe_pkg::MAX_TILES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic                              cfg_index_i,
  input  wire logic [rtpe_pkg::COLOR_W-1:0]      cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [7:0]                        in_red_i,
  input  wire logic [7:0]                        in_green_i,
  input  wire logic [7:0]                        in_blue_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              out_kind_o,
  output      logic [rtpe_pkg::COLOR_W-1:0]      out_color_o,
  output      logic [rtpe_pkg::IDX_W-1:0]        out_color_index_o,
  output      logic                              out_new_entry_o,
  output      logic                              out_palette_error_o,
  output      logic [7:0]                        out_plane_byte_o,
  output      logic [4:0]                        out_byte_offset_o,
  output      logic [rtpe_pkg::TILE_OUT_W-1:0]   out_tile_number_o,
  output      logic                              out_last_o
);

  rtpe_pkg::mode_e              mode_q;
  logic [rtpe_pkg::COLOR_W-1:0] bg_q;
  rtpe_pkg::q_status_t          q_status;
  rtpe_pkg::rec_t               push_rec, head_rec;
  logic                         push, pop;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rtpe_pkg::MODE_COLLECT;
      bg_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rtpe_pkg::CFG_MODE: mode_q <= rtpe_pkg::mode_e'(cfg_data_i[0]);
        rtpe_pkg::CFG_BG:   bg_q   <= cfg_data_i;
        default:            mode_q <= mode_q;
      endcase
    end
  end

  // pixel intake, palette lookup and row assembly
  rtpe_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_TILES     (MAX_TILES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_q),
    .bg_color_i (bg_q),
    .q_status_i (q_status),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  // job queue between front and back
  rtpe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_rec_o (head_rec),
    .status_o   (q_status)
  );

  // result sequencing
  rtpe_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_rec_i          (head_rec),
    .q_status_i          (q_status),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_kind_o          (out_kind_o),
    .out_color_o         (out_color_o),
    .out_color_index_o   (out_color_index_o),
    .out_new_entry_o     (out_new_entry_o),
    .out_palette_error_o (out_palette_error_o),
    .out_plane_byte_o    (out_plane_byte_o),
    .out_byte_offset_o   (out_byte_offset_o),
    .out_tile_number_o   (out_tile_number_o),
    .out_last_o          (out_last_o)
  );

  // checks
  `RTPE_ASSERT(a_push_shows, clk_i, rst_ni, (push && q_status.empty) |=> out_valid_o, "queued job not shown")
  `RTPE_ASSERT(a_last_offset, clk_i, rst_ni, (out_valid_o && out_last_o) |-> (out_kind_o && out_byte_offset_o[4] && out_byte_offset_o[0]), "last byte at wrong offset")
  `RTPE_ASSERT_NEVER(a_new_err, clk_i, rst_ni, out_valid_o && out_new_entry_o && (out_kind_o || out_palette_error_o), "new entry with error or plane kind")
  `RTPE_ASSERT(a_report_clean, clk_i, rst_ni, (out_valid_o && !out_kind_o) |-> (out_plane_byte_o == 8'h00 && out_byte_offset_o == 5'd0 && !out_last_o), "report carries plane data")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpe_pkg::*;

  localparam int RAND_PIXELS    = 310;
  localparam int CLOSE_PIXELS   = 32;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIR          = 26;

  // one output item as the block should present it
  typedef struct packed {
    kind_e                 kind;
    logic [COLOR_W-1:0]    color;
    logic [IDX_W-1:0]      idx;
    logic                  new_entry;
    logic                  err;
    logic [7:0]            plane;
    logic [4:0]            offset;
    logic [TILE_OUT_W-1:0] tile;
    logic                  last;
  } result_t;

  // one line of the directed sequence: a register write or a pixel
  typedef struct packed {
    logic               is_wr;
    cfg_idx_e           widx;
    logic [COLOR_W-1:0] wdata;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               typed;
    logic [COLOR_W-1:0] t_color;
    logic [IDX_W-1:0]   t_idx;
    logic               t_new;
    logic               t_err;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i = 1'b0;
  logic [COLOR_W-1:0]    cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            in_red_i = '0;
  logic [7:0]            in_green_i = '0;
  logic [7:0]            in_blue_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  out_kind_o;
  logic [COLOR_W-1:0]    out_color_o;
  logic [IDX_W-1:0]      out_color_index_o;
  logic                  out_new_entry_o;
  logic                  out_palette_error_o;
  logic [7:0]            out_plane_byte_o;
  logic [4:0]            out_byte_offset_o;
  logic [TILE_OUT_W-1:0] out_tile_number_o;
  logic                  out_last_o;

  rgb_to_planar_tile_encoder_core dut (.*);

  always #4 clk_i = ~clk_i;

  // mirror of the block's registers and state
  mode_e              cur_mode = MODE_COLLECT;
  logic [COLOR_W-1:0] bg_color = '0;
  logic [COLOR_W-1:0] pal [16];
  int                 pal_used = 0;
  logic [7:0]         acc [4] = '{default: '0};
  int                 col_pos = 0;
  int                 row_pos = 0;
  int                 tile_cnt = 0;
  bit                 row_err = 1'b0;

  result_t result_items_q [$];

  // traffic shaping
  int   gap_pct = 20;
  int   stall_pct = 20;
  logic hold_req = 1'b0;
  bit   hold_done = 1'b0;
  bit   saw_in_stall = 1'b0;

  // run statistics
  int n_errors = 0;
  int n_pixels = 0;
  int n_rand = 0;
  int n_results = 0;
  int n_overflow = 0;
  int n_rows = 0;
  int n_bad_rows = 0;
  int quiet_cycles = 0;

  function automatic int pal_find(logic [COLOR_W-1:0] c);
    for (int i = 0; i < pal_used; i++)
      if (pal[i] == c) return i;
    return -1;
  endfunction

  // bgr555 conversion, palette lookup and plane packing for one pixel
  function automatic void convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [COLOR_W-1:0] c;
    logic [IDX_W-1:0]   idx;
    int                 pos;
    int                 bpos;
    result_t            res;
    c = {b[7:3], g[7:3], r[7:3]};
    pos = pal_find(c);
    res = '0;
    res.color = c;
    // collect: report hit, append, or flag a full palette
    if (cur_mode == MODE_COLLECT) begin
      res.kind = KIND_REPORT;
      if (pos >= 0) begin
        res.idx = pos[3:0];
      end else if (pal_used < PALETTE_DEPTH_DEF) begin
        pal[pal_used] = c;
        res.idx = pal_used[3:0];
        res.new_entry = 1'b1;
        pal_used++;
      end else begin
        res.err = 1'b1;
        n_overflow++;
      end
      result_items_q.insert(result_items_q.size(), res);
      return;
    end
    // encode: background always maps to zero, entry 0 takes its slot
    if (c == bg_color) begin
      idx = '0;
    end else if (pos == 0) begin
      bpos = pal_find(bg_color);
      if (bpos > 0) begin
        idx = bpos[3:0];
      end else begin
        idx = '0;
        row_err = 1'b1;
      end
    end else if (pos > 0) begin
      idx = pos[3:0];
    end else begin
      idx = '0;
      row_err = 1'b1;
    end
    for (int p = 0; p < 4; p++)
      acc[p] = acc[p] | (8'(idx[p]) << (7 - col_pos));
    if (col_pos < 7) begin
      col_pos++;
      return;
    end
    // row complete: four plane bytes
    res.kind = KIND_PLANE;
    res.idx  = idx;
    res.err  = row_err;
    res.tile = tile_cnt[9:0];
    for (int p = 0; p < 4; p++) begin
      res.plane  = acc[p];
      res.offset = 5'(2 * row_pos + (p % 2) + (p / 2) * 16);
      res.last   = (p == 3);
      result_items_q.insert(result_items_q.size(), res);
    end
    n_rows++;
    if (row_err) n_bad_rows++;
    acc = '{default: '0};
    row_err = 1'b0;
    col_pos = 0;
    if (row_pos < 7) begin
      row_pos++;
    end else begin
      row_pos = 0;
      tile_cnt++;
      if (tile_cnt >= MAX_TILES_DEF) begin
        tile_cnt = 0;
      end
    end
  endfunction

  function automatic void cmp(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // output side: compare each item with the oldest pending one
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      n_results++;
      if (result_items_q.size() == 0) begin
        $error("output item arrived with nothing pending");
        n_errors++;
      end else begin
        want = result_items_q.pop_front();
        cmp("kind", want.kind, out_kind_o);
        cmp("color", want.color, out_color_o);
        cmp("color_index", want.idx, out_color_index_o);
        cmp("new_entry", want.new_entry, out_new_entry_o);
        cmp("palette_error", want.err, out_palette_error_o);
        cmp("plane_byte", want.plane, out_plane_byte_o);
        cmp("byte_offset", want.offset, out_byte_offset_o);
        cmp("tile_number", want.tile, out_tile_number_o);
        cmp("last", want.last, out_last_o);
      end
    end
  end

  // output stall: random bursts, plus one long hold-off on request
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left > 0) left--;
      if (left == 0) begin
        if (hold_req && !hold_done) begin
          left = HOLD_CYCLES;
          hold_done = 1'b1;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
          left = $urandom_range(8, 1);
        end
      end
      out_stall_i <= (left > 0);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** rgb_to_planar_tile_encoder_core: FAILED **");
      $finish;
    end
  end

  // wait until all output items are in and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (result_items_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e which, logic [COLOR_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    if (which == CFG_MODE) cur_mode = mode_e'(data[0]);
    else bg_color = data;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_red_i   <= r;
    in_green_i <= g;
    in_blue_i  <= b;
    do begin
      @(posedge clk_i);
      if (in_stall_o === 1'b1) saw_in_stall = 1'b1;
    end while (in_stall_o !== 1'b0);
    convert_pixel(r, g, b);
    n_pixels++;
  endtask

  // palette colours, background or noise, with random truncated bits
  task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g,
                            output logic [7:0] b);
    logic [COLOR_W-1:0] c;
    int roll;
    bit enc;
    enc  = (cur_mode == MODE_ENCODE);
    roll = $urandom_range(99);
    if (pal_used > 0 && roll < (enc ? 70 : 40)) begin
      c = pal[$urandom_range(pal_used - 1)];
    end else if (enc && roll < 85) begin
      c = bg_color;
    end else begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      return;
    end
    r = {c[4:0], 3'($urandom)};
    g = {c[9:5], 3'($urandom)};
    b = {c[14:10], 3'($urandom)};
  endtask

  function automatic logic [COLOR_W-1:0] pick_bg();
    int roll;
    roll = $urandom_range(99);
    if (pal_used > 0 && roll < 50) return pal[$urandom_range(pal_used - 1)];
    if (roll < 65) return '0;
    if (roll < 80) return '1;
    return COLOR_W'($urandom);
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic dir_row_t reg_row(cfg_idx_e which, logic [COLOR_W-1:0] data);
    dir_row_t d;
    d = '0;
    d.is_wr = 1'b1;
    d.widx  = which;
    d.wdata = data;
    return d;
  endfunction

  function automatic dir_row_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    dir_row_t d;
    d = '0;
    d.r = r;
    d.g = g;
    d.b = b;
    return d;
  endfunction

  function automatic dir_row_t pix_row_chk(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [COLOR_W-1:0] color, logic [IDX_W-1:0] idx,
                                           logic nw, logic err);
    dir_row_t d;
    d = pix_row(r, g, b);
    d.typed   = 1'b1;
    d.t_color = color;
    d.t_idx   = idx;
    d.t_new   = nw;
    d.t_err   = err;
    return d;
  endfunction

  initial begin
    dir_row_t   rows [N_DIR];
    result_t    fixed;
    logic [7:0] r, g, b;
    mode_e      m;
    int         n;
    int         phase;

    rows = '{
      reg_row(CFG_MODE, 15'(MODE_COLLECT)),
      reg_row(CFG_BG, 15'h7fff),
      // palette fill from empty, one repeat
      pix_row_chk(8'd0,   8'd0,   8'd0,   15'h0000, 4'd0, 1'b1, 1'b0),
      pix_row_chk(8'd255, 8'd255, 8'd255, 15'h7fff, 4'd1, 1'b1, 1'b0),
      pix_row_chk(8'd7,   8'd7,   8'd7,   15'h0000, 4'd0, 1'b0, 1'b0),
      pix_row_chk(8'd255, 8'd0,   8'd0,   15'h001f, 4'd2, 1'b1, 1'b0),
      pix_row_chk(8'd0,   8'd255, 8'd0,   15'h03e0, 4'd3, 1'b1, 1'b0),
      pix_row_chk(8'd0,   8'd0,   8'd255, 15'h7c00, 4'd4, 1'b1, 1'b0),
      reg_row(CFG_MODE, 15'(MODE_ENCODE)),
      // background in the palette: swap with entry 0, one unknown colour
      pix_row(8'd255, 8'd255, 8'd255),
      pix_row(8'd0,   8'd0,   8'd0),
      pix_row(8'd255, 8'd0,   8'd0),
      pix_row(8'd0,   8'd255, 8'd0),
      pix_row(8'd0,   8'd0,   8'd255),
      pix_row(8'd8,   8'd8,   8'd8),
      pix_row(8'd255, 8'd255, 8'd255),
      pix_row(8'd0,   8'd0,   8'd0),
      reg_row(CFG_BG, 15'h1234),
      // background not in the palette: entry 0 no longer found
      pix_row(8'd160, 8'd136, 8'd32),
      pix_row(8'd0,   8'd0,   8'd0),
      pix_row(8'd255, 8'd255, 8'd255),
      pix_row(8'd255, 8'd0,   8'd0),
      pix_row(8'd160, 8'd136, 8'd32),
      pix_row(8'd0,   8'd255, 8'd0),
      pix_row(8'd0,   8'd0,   8'd255),
      pix_row(8'd7,   8'd7,   8'd7)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sequence
    foreach (rows[i]) begin
      if (rows[i].is_wr) begin
        write_reg(rows[i].widx, rows[i].wdata);
      end else begin
        send_pixel(rows[i].r, rows[i].g, rows[i].b);
        if (rows[i].typed) begin
          fixed = '0;
          fixed.kind      = KIND_REPORT;
          fixed.color     = rows[i].t_color;
          fixed.idx       = rows[i].t_idx;
          fixed.new_entry = rows[i].t_new;
          fixed.err       = rows[i].t_err;
          result_items_q[result_items_q.size() - 1] = fixed;
        end
      end
    end

    // random phases; the first one fills the palette under a long output hold
    phase = 0;
    while (n_rand < RAND_PIXELS) begin
      m = (phase == 0) ? MODE_COLLECT : mode_e'($urandom_range(1));
      write_reg(CFG_MODE, 15'(m));
      if (m == MODE_ENCODE && $urandom_range(99) < 80) write_reg(CFG_BG, pick_bg());
      gap_pct = pick_rate();
      stall_pct <= pick_rate();
      if (m == MODE_COLLECT) n = $urandom_range(40, 8);
      else if ($urandom_range(3) != 0) n = 8 * $urandom_range(6, 1);
      else n = $urandom_range(30, 1);
      if (phase == 0) begin
        gap_pct = 0;
        hold_req <= 1'b1;
        n = 40;
      end
      repeat (n) begin
        pick_pixel(r, g, b);
        send_pixel(r, g, b);
      end
      n_rand += n;
      phase++;
    end

    // closing sweep of four encode rows without idling
    gap_pct = 0;
    stall_pct <= 0;
    write_reg(CFG_MODE, 15'(MODE_ENCODE));
    write_reg(CFG_BG, (pal_used > 1) ? pal[1] : '0);
    repeat (CLOSE_PIXELS) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end

    in_valid_i <= 1'b0;
    while (result_items_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d pixels (%0d random), %0d output items, %0d palette-full reports",
             n_pixels, n_rand, n_results, n_overflow);
    $display("run: %0d rows (%0d with unmatched colours), tile reached %0d, input stalled %0d",
             n_rows, n_bad_rows, tile_cnt, saw_in_stall);
    if (n_errors == 0) begin
      $display("** rgb_to_planar_tile_encoder_core: PASSED **");
    end else begin
      $display("** rgb_to_planar_tile_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule
